@@ rtl/hmd_pkg.sv @@
// Shared types, constants and helper functions of the handheld memory map block.
`default_nettype none

package hmd_pkg;

    // Address widths of the two stores.
    localparam int MAIN_AW = 16;
    localparam int BOOT_AW = 8;
    localparam int MAIN_DEPTH = 1 << MAIN_AW;
    localparam int BOOT_DEPTH = 1 << BOOT_AW;

    // Machine cycles between the start of an object table transfer and the copy.
    localparam logic [7:0] DMA_DELAY = 8'd160;

    // Memory map landmarks.
    localparam logic [15:0] ROM_TOP      = 16'h7FFF;
    localparam logic [15:0] VRAM_BASE    = 16'h8000;
    localparam logic [15:0] VRAM_TOP     = 16'h9FFF;
    localparam logic [15:0] OAM_BASE     = 16'hFE00;
    localparam logic [15:0] OAM_TOP      = 16'hFE9F;
    localparam logic [15:0] UNUSED_BASE  = 16'hFEA0;
    localparam logic [15:0] UNUSED_TOP   = 16'hFEFF;
    localparam logic [15:0] BOOT_LIMIT   = 16'h0100;
    localparam logic [15:0] AD_JOYPAD    = 16'hFF00;
    localparam logic [15:0] AD_DIVIDER   = 16'hFF04;
    localparam logic [15:0] AD_DMA       = 16'hFF46;
    localparam logic [15:0] AD_BOOT_OFF  = 16'hFF50;
    localparam logic [7:0]  OAM_PAGE     = 8'hFE;
    localparam logic [7:0]  BLOCKED_BYTE = 8'hFF;
    localparam logic [7:0]  BOOT_OFF_SET = 8'h01;

    // Only the first 160 bytes of the object table can take a write.
    localparam logic [7:0]  OAM_LAST_IDX = 8'h9F;

    typedef enum logic [2:0] {
        CMD_READ      = 3'd0,
        CMD_WRITE     = 3'd1,
        CMD_TICK      = 3'd2,
        CMD_LOAD_ROM  = 3'd3,
        CMD_LOAD_BOOT = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_DMA_RD,
        ST_DMA_WR,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] address;
        logic [7:0]  data_in;
        logic [7:0]  tick_cycles;
        logic        video_locked;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       divider_reset;
        logic       joypad_write;
        logic [7:0] joypad_value;
        logic       dma_finished;
        logic       dma_busy;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;
        logic clear;
        logic exec;
        logic read_cap;
        logic dma_rd;
        logic dma_wr;
        logic push;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;
        logic clear_last;
        logic is_read;
        logic copy_go;
        logic dma_last;
        logic out_free;
    } st_t;

    function automatic logic is_blocked(input logic [15:0] a, input logic locked);
        logic vram;
        logic oam;
        logic unused;
        vram   = (a >= VRAM_BASE) && (a <= VRAM_TOP);
        oam    = (a >= OAM_BASE) && (a <= OAM_TOP);
        unused = (a >= UNUSED_BASE) && (a <= UNUSED_TOP);
        return (locked && (vram || oam)) || unused;
    endfunction

endpackage

`default_nettype wire

@@ rtl/hmd_req_if.sv @@
// Request channel interface: handshake plus one memory map request.
`default_nettype none

interface hmd_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [15:0] address;
    logic [7:0]  data_in;
    logic [7:0]  tick_cycles;
    logic        video_locked;

    modport source (
        output valid, command, address, data_in, tick_cycles, video_locked,
        input  ready
    );

    modport sink (
        input  valid, command, address, data_in, tick_cycles, video_locked,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/hmd_rsp_if.sv @@
// Response channel interface: handshake plus one memory map result.
`default_nettype none

interface hmd_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       divider_reset;
    logic       joypad_write;
    logic [7:0] joypad_value;
    logic       dma_finished;
    logic       dma_busy;

    modport source (
        output valid, read_data, divider_reset, joypad_write, joypad_value,
               dma_finished, dma_busy,
        input  ready
    );

    modport sink (
        input  valid, read_data, divider_reset, joypad_write, joypad_value,
               dma_finished, dma_busy,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/handheld_memory_map_with_oam_dma_unit.sv @@
// Top level of the handheld memory map with object table DMA.
`default_nettype none

// This block is a 64 KiB byte memory map with a 256-byte boot ROM overlay on the
// low page, driven by one request at a time on the req channel and answering
// each request with exactly one result on the rsp channel. After reset the block
// first sweeps the whole main store to zero, one byte per clock, and req.ready
// stays low until the sweep ends; the boot ROM is not cleared and must be loaded
// before it is read. A read passes through latch, store access, registered RAM
// read and push before its result reaches the output register; writes, ticks
// and loads skip the registered RAM read. A tick that completes an object table
// transfer with video unlocked copies the 160 writable object table bytes, each
// by a read and a write step through the main store's single read and single
// write port; with video locked no byte lands, the copy is skipped and the tick
// costs no more than any other. The output register holds a finished result
// while the next request is already being accepted and worked on; a finished
// result waits in the push state until that register is free.
module handheld_memory_map_with_oam_dma_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    hmd_req_if.sink   req,
    hmd_rsp_if.source rsp
);

    // Commands flow from the controller to the datapath; status flows back.
    hmd_pkg::ctl_t ctl;
    hmd_pkg::st_t  st;

    // The controller owns sequencing: the clearing pass, the request steps and
    // the byte loop of the object table copy.
    hmd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctl   (ctl)
    );

    // The datapath owns both stores, the access rules, the DMA counters and the
    // output register.
    hmd_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .ctl   (ctl),
        .st    (st)
    );

`ifndef SYNTHESIS
    // Only one request is in flight: an acceptance is never followed at once by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another request is in flight");

    // A result is only pushed when the output register is empty or draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> (!rsp.valid || rsp.ready))
    else $error("result pushed over a waiting result");

    // A tick that finishes the transfer leaves no transfer pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.dma_finished && rsp.dma_busy))
    else $error("transfer reported finished and still busy");

    // No request is taken while the main store is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |-> !req.ready)
    else $error("request accepted during the clearing pass");
`endif

endmodule

`default_nettype wire

@@ rtl/hmd_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module hmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/hmd_ctrl.sv @@
// Controller state machine that sequences clearing, requests and the object table copy.
`default_nettype none

module hmd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hmd_pkg::st_t  st,
    output hmd_pkg::ctl_t      ctl
);

    hmd_pkg::state_t state_reg;
    hmd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hmd_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hmd_pkg::ST_CLEAR:
            begin
                if (st.clear_last)
                begin
                    state_next = hmd_pkg::ST_IDLE;
                end
            end
            hmd_pkg::ST_IDLE:
            begin
                if (st.in_valid)
                begin
                    state_next = hmd_pkg::ST_EXEC;
                end
            end
            hmd_pkg::ST_EXEC:
            begin
                if (st.is_read)
                begin
                    state_next = hmd_pkg::ST_READ;
                end
                else if (st.copy_go)
                begin
                    state_next = hmd_pkg::ST_DMA_RD;
                end
                else
                begin
                    state_next = hmd_pkg::ST_PUSH;
                end
            end
            hmd_pkg::ST_READ:
            begin
                state_next = hmd_pkg::ST_PUSH;
            end
            hmd_pkg::ST_DMA_RD:
            begin
                state_next = hmd_pkg::ST_DMA_WR;
            end
            hmd_pkg::ST_DMA_WR:
            begin
                state_next = st.dma_last ? hmd_pkg::ST_PUSH : hmd_pkg::ST_DMA_RD;
            end
            hmd_pkg::ST_PUSH:
            begin
                if (st.out_free)
                begin
                    state_next = hmd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hmd_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        ctl          = '0;
        ctl.ready    = (state_reg == hmd_pkg::ST_IDLE);
        ctl.clear    = (state_reg == hmd_pkg::ST_CLEAR);
        ctl.exec     = (state_reg == hmd_pkg::ST_EXEC);
        ctl.read_cap = (state_reg == hmd_pkg::ST_READ);
        ctl.dma_rd   = (state_reg == hmd_pkg::ST_DMA_RD);
        ctl.dma_wr   = (state_reg == hmd_pkg::ST_DMA_WR);
        ctl.push     = (state_reg == hmd_pkg::ST_PUSH) && st.out_free;
    end

endmodule

`default_nettype wire

@@ rtl/hmd_datapath.sv @@
// Datapath: request and result registers, both stores, access rules and DMA counters.
`default_nettype none

module hmd_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    hmd_req_if.sink            req,
    hmd_rsp_if.source          rsp,
    input  wire hmd_pkg::ctl_t ctl,
    output hmd_pkg::st_t       st
);

    // Picks the byte a read sees: blocked, boot overlay or main store.
    function automatic logic [7:0] pick_byte(
        input logic [15:0] a,
        input logic        locked,
        input logic [7:0]  boot_off,
        input logic [7:0]  boot_q,
        input logic [7:0]  main_q
    );
        logic [7:0] v;
        if (hmd_pkg::is_blocked(a, locked))
        begin
            v = hmd_pkg::BLOCKED_BYTE;
        end
        else if ((a < hmd_pkg::BOOT_LIMIT) && (boot_off == 8'h00))
        begin
            v = boot_q;
        end
        else
        begin
            v = main_q;
        end
        return v;
    endfunction

    hmd_pkg::req_t req_reg, req_next;
    hmd_pkg::res_t res_reg, res_next;
    hmd_pkg::res_t out_reg, out_next;
    logic          out_valid_reg, out_valid_next;
    logic          dma_pending_reg, dma_pending_next;
    logic [7:0]    dma_elapsed_reg, dma_elapsed_next;
    logic [7:0]    dma_page_reg, dma_page_next;
    logic [7:0]    dma_idx_reg, dma_idx_next;
    logic [7:0]    boot_off_reg, boot_off_next;
    logic [hmd_pkg::MAIN_AW-1:0] clr_reg, clr_next;

    logic [15:0] a;
    logic        blocked;
    logic        wr_ok;
    logic        cmd_read, cmd_write, cmd_tick, cmd_rom, cmd_boot;
    logic        hit_div, hit_dma, hit_joy, wr_store;
    logic [7:0]  tick_sum;
    logic        tick_fire;
    logic [15:0] dma_src;
    logic [7:0]  dma_val;
    logic [7:0]  rd_val;

    logic                        main_we;
    logic [hmd_pkg::MAIN_AW-1:0] main_waddr, main_raddr;
    logic [7:0]                  main_wdata, main_q;
    logic                        boot_we;
    logic [hmd_pkg::BOOT_AW-1:0] boot_raddr;
    logic [7:0]                  boot_q;

    assign a         = req_reg.address;
    assign blocked   = hmd_pkg::is_blocked(a, req_reg.video_locked);
    assign cmd_read  = (req_reg.command == hmd_pkg::CMD_READ);
    assign cmd_write = (req_reg.command == hmd_pkg::CMD_WRITE);
    assign cmd_tick  = (req_reg.command == hmd_pkg::CMD_TICK);
    assign cmd_rom   = (req_reg.command == hmd_pkg::CMD_LOAD_ROM);
    assign cmd_boot  = (req_reg.command == hmd_pkg::CMD_LOAD_BOOT);

    // The boot-off byte locks itself once it holds exactly one.
    assign wr_ok = cmd_write && (a > hmd_pkg::ROM_TOP) && !blocked
                   && !((a == hmd_pkg::AD_BOOT_OFF) && (boot_off_reg == hmd_pkg::BOOT_OFF_SET));
    assign hit_div  = wr_ok && (a == hmd_pkg::AD_DIVIDER);
    assign hit_dma  = wr_ok && (a == hmd_pkg::AD_DMA);
    assign hit_joy  = wr_ok && (a == hmd_pkg::AD_JOYPAD);
    assign wr_store = wr_ok && !hit_div && !hit_dma && !hit_joy;

    assign tick_sum  = dma_elapsed_reg + req_reg.tick_cycles;
    assign tick_fire = cmd_tick && dma_pending_reg && (tick_sum >= hmd_pkg::DMA_DELAY);

    assign dma_src = {dma_page_reg, dma_idx_reg};
    assign dma_val = pick_byte(dma_src, 1'b0, boot_off_reg, boot_q, main_q);
    assign rd_val  = pick_byte(a, req_reg.video_locked, boot_off_reg, boot_q, main_q);

    // Store ports.
    always_comb
    begin
        main_we    = 1'b0;
        main_waddr = a;
        main_wdata = req_reg.data_in;
        if (ctl.clear)
        begin
            main_we    = 1'b1;
            main_waddr = clr_reg;
            main_wdata = 8'h00;
        end
        else if (ctl.exec)
        begin
            main_we = wr_store || cmd_rom;
        end
        else if (ctl.dma_wr)
        begin
            main_we    = 1'b1;
            main_waddr = {hmd_pkg::OAM_PAGE, dma_idx_reg};
            main_wdata = dma_val;
        end
    end

    assign main_raddr = ctl.dma_rd ? dma_src : a;
    assign boot_raddr = ctl.dma_rd ? dma_idx_reg : a[hmd_pkg::BOOT_AW-1:0];
    assign boot_we    = ctl.exec && cmd_boot;

    hmd_ram #(
        .WIDTH (8),
        .DEPTH (hmd_pkg::MAIN_DEPTH)
    ) u_main_ram (
        .clk   (clk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (main_wdata),
        .raddr (main_raddr),
        .rdata (main_q)
    );

    hmd_ram #(
        .WIDTH (8),
        .DEPTH (hmd_pkg::BOOT_DEPTH)
    ) u_boot_ram (
        .clk   (clk),
        .we    (boot_we),
        .waddr (a[hmd_pkg::BOOT_AW-1:0]),
        .wdata (req_reg.data_in),
        .raddr (boot_raddr),
        .rdata (boot_q)
    );

    // Next-state logic for all registers.
    always_comb
    begin
        req_next         = req_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;
        dma_pending_next = dma_pending_reg;
        dma_elapsed_next = dma_elapsed_reg;
        dma_page_next    = dma_page_reg;
        dma_idx_next     = dma_idx_reg;
        boot_off_next    = boot_off_reg;
        clr_next         = clr_reg;

        if (ctl.clear)
        begin
            clr_next = clr_reg + 1'b1;
        end

        if (ctl.ready && req.valid)
        begin
            req_next.command      = req.command;
            req_next.address      = req.address;
            req_next.data_in      = req.data_in;
            req_next.tick_cycles  = req.tick_cycles;
            req_next.video_locked = req.video_locked;
        end

        if (ctl.exec)
        begin
            if (hit_dma)
            begin
                dma_page_next    = req_reg.data_in;
                dma_pending_next = 1'b1;
                dma_elapsed_next = 8'h00;
            end
            else if (cmd_tick && dma_pending_reg)
            begin
                dma_elapsed_next = tick_sum;
                if (tick_fire)
                begin
                    dma_pending_next = 1'b0;
                end
            end
            if (main_we && (a == hmd_pkg::AD_BOOT_OFF))
            begin
                boot_off_next = req_reg.data_in;
            end
            dma_idx_next           = 8'h00;
            res_next.read_data     = 8'h00;
            res_next.divider_reset = hit_div;
            res_next.joypad_write  = hit_joy;
            res_next.joypad_value  = hit_joy ? req_reg.data_in : 8'h00;
            res_next.dma_finished  = tick_fire;
            res_next.dma_busy      = dma_pending_next;
        end

        if (ctl.read_cap)
        begin
            res_next.read_data = rd_val;
        end

        if (ctl.dma_wr)
        begin
            dma_idx_next = dma_idx_reg + 1'b1;
        end

        if (ctl.push)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            dma_pending_reg <= 1'b0;
            dma_elapsed_reg <= 8'h00;
            dma_page_reg    <= 8'h00;
            dma_idx_reg     <= 8'h00;
            boot_off_reg    <= 8'h00;
            clr_reg         <= '0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            dma_pending_reg <= dma_pending_next;
            dma_elapsed_reg <= dma_elapsed_next;
            dma_page_reg    <= dma_page_next;
            dma_idx_reg     <= dma_idx_next;
            boot_off_reg    <= boot_off_next;
            clr_reg         <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign req.ready = ctl.ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = out_reg.read_data;
    assign rsp.divider_reset = out_reg.divider_reset;
    assign rsp.joypad_write  = out_reg.joypad_write;
    assign rsp.joypad_value  = out_reg.joypad_value;
    assign rsp.dma_finished  = out_reg.dma_finished;
    assign rsp.dma_busy      = out_reg.dma_busy;

    always_comb
    begin
        st            = '0;
        st.in_valid   = req.valid;
        st.clear_last = (clr_reg == {hmd_pkg::MAIN_AW{1'b1}});
        st.is_read    = cmd_read;
        st.copy_go    = tick_fire && !req_reg.video_locked;
        st.dma_last   = (dma_idx_reg == hmd_pkg::OAM_LAST_IDX);
        st.out_free   = !out_valid_reg || rsp.ready;
    end

endmodule

`default_nettype wire

@@ sim/hmd_result_checker.sv @@
// Checker that watches the request and result channels and compares every result.
`timescale 1ns / 1ps

module hmd_result_checker (
    input  logic clk,
    input  logic rst_n,
    hmd_req_if   req,
    hmd_rsp_if   rsp,
    output int   fail_count,
    output int   pending_results
);
    import hmd_pkg::*;

    typedef enum logic [1:0] {
        HIT_NONE,
        HIT_DIVIDER,
        HIT_JOYPAD
    } reg_hit_e;

    localparam int SHOWN_LIMIT = 50;

    // Own copy of the memory map and the object table transfer state.
    logic [7:0] main_mem [0:MAIN_DEPTH-1];
    logic [7:0] boot_mem [0:BOOT_DEPTH-1];
    logic       xfer_pending;
    logic [7:0] xfer_elapsed;
    logic [7:0] xfer_page;

    res_t due_results [$];

    initial
    begin
        for (int i = 0; i < MAIN_DEPTH; i++)
            main_mem[i] = 8'h00;
        for (int i = 0; i < BOOT_DEPTH; i++)
            boot_mem[i] = 8'h00;
        xfer_pending    = 1'b0;
        xfer_elapsed    = 8'h00;
        xfer_page       = 8'h00;
        fail_count      = 0;
        pending_results = 0;
    end

    function automatic logic region_blocked(input logic [15:0] a, input logic lk);
        if (a >= UNUSED_BASE && a <= UNUSED_TOP)
            return 1'b1;
        if (!lk)
            return 1'b0;
        return (a >= VRAM_BASE && a <= VRAM_TOP) || (a >= OAM_BASE && a <= OAM_TOP);
    endfunction

    function automatic logic [7:0] map_read(input logic [15:0] a, input logic lk);
        if (region_blocked(a, lk))
            return BLOCKED_BYTE;
        if (a < BOOT_LIMIT && main_mem[AD_BOOT_OFF] == 8'h00)
            return boot_mem[a[7:0]];
        return main_mem[a];
    endfunction

    // Writes land in the store unless dropped or taken by a special register.
    function automatic reg_hit_e map_write(input logic [15:0] a, input logic [7:0] v,
                                           input logic lk);
        if (a <= ROM_TOP || region_blocked(a, lk))
            return HIT_NONE;
        if (a == AD_BOOT_OFF && main_mem[AD_BOOT_OFF] == BOOT_OFF_SET)
            return HIT_NONE;
        if (a == AD_DIVIDER)
            return HIT_DIVIDER;
        if (a == AD_JOYPAD)
            return HIT_JOYPAD;
        if (a == AD_DMA)
        begin
            xfer_page    = v;
            xfer_pending = 1'b1;
            xfer_elapsed = 8'h00;
            return HIT_NONE;
        end
        main_mem[a] = v;
        return HIT_NONE;
    endfunction

    function automatic res_t apply_request(input req_t r);
        res_t     res;
        reg_hit_e hit;
        logic [7:0] off;
        res = '0;
        case (r.command)
            CMD_READ:
                res.read_data = map_read(r.address, r.video_locked);
            CMD_WRITE:
            begin
                hit = map_write(r.address, r.data_in, r.video_locked);
                res.divider_reset = (hit == HIT_DIVIDER);
                if (hit == HIT_JOYPAD)
                begin
                    res.joypad_write = 1'b1;
                    res.joypad_value = r.data_in;
                end
            end
            CMD_TICK:
                if (xfer_pending)
                begin
                    xfer_elapsed = xfer_elapsed + r.tick_cycles;
                    if (xfer_elapsed >= DMA_DELAY)
                    begin
                        xfer_pending = 1'b0;
                        res.dma_finished = 1'b1;
                        for (int i = 0; i < 256; i++)
                        begin
                            off = i[7:0];
                            void'(map_write({OAM_PAGE, off},
                                            map_read({xfer_page, off}, r.video_locked),
                                            r.video_locked));
                        end
                    end
                end
            CMD_LOAD_ROM:
                main_mem[r.address] = r.data_in;
            CMD_LOAD_BOOT:
                boot_mem[r.address[7:0]] = r.data_in;
            default:
                ;
        endcase
        res.dma_busy = xfer_pending;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < SHOWN_LIMIT)
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        req_t r;
        res_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_results.size() == 0)
                    report_mismatch("result with no request waiting", rsp.read_data, 0);
                else
                begin
                    want = due_results.pop_front();
                    if (rsp.read_data !== want.read_data)
                        report_mismatch("read_data", rsp.read_data, want.read_data);
                    if (rsp.divider_reset !== want.divider_reset)
                        report_mismatch("divider_reset", rsp.divider_reset, want.divider_reset);
                    if (rsp.joypad_write !== want.joypad_write)
                        report_mismatch("joypad_write", rsp.joypad_write, want.joypad_write);
                    if (rsp.joypad_value !== want.joypad_value)
                        report_mismatch("joypad_value", rsp.joypad_value, want.joypad_value);
                    if (rsp.dma_finished !== want.dma_finished)
                        report_mismatch("dma_finished", rsp.dma_finished, want.dma_finished);
                    if (rsp.dma_busy !== want.dma_busy)
                        report_mismatch("dma_busy", rsp.dma_busy, want.dma_busy);
                end
            end
            if (req.valid && req.ready)
            begin
                r.command      = req.command;
                r.address      = req.address;
                r.data_in      = req.data_in;
                r.tick_cycles  = req.tick_cycles;
                r.video_locked = req.video_locked;
                due_results.push_back(apply_request(r));
            end
        end
        pending_results <= due_results.size();
    end

endmodule

@@ sim/testbench.sv @@
// Top of the memory map test: clock, reset, request stimulus, result pacing and verdict.
`timescale 1ns / 1ps

module testbench;
    import hmd_pkg::*;

    // The run is cut off here only if something hangs; a correct run, even with
    // every request paying the full object table copy, ends far below it.
    localparam int LIMIT_CYCLES    = 2000000;
    localparam int RANDOM_ITEMS    = 850;
    // Longest single request (a copying tick) plus both pipeline stages.
    localparam int DRAIN_CYCLES    = 400;
    // Once this many results have been taken, the receiver stops for a while.
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 400;

    // Command codes that the block does not use.
    localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
    localparam logic [2:0]  CMD_SPARE_HI = 3'd7;

    // Small windows of work RAM and high RAM, so that writes and reads meet.
    localparam logic [15:0] WRAM_BASE = 16'hC000;
    localparam logic [15:0] HRAM_BASE = 16'hFF80;
    localparam logic [15:0] IO_BASE   = 16'hFF00;
    localparam logic [15:0] ROM_LOW   = 16'h0100;
    localparam logic [7:0]  WRAM_PAGE = 8'hC0;
    localparam logic [7:0]  VRAM_PAGE = 8'h80;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_results;
    int   cycle_count = 0;
    int   sent_count = 0;
    bit   calm_sender = 1'b0;
    bit   calm_receiver = 1'b0;

    // What the stimulus must know to never read a boot ROM entry that was not
    // loaded: which entries hold a byte, and the value of the boot-off byte.
    bit         boot_loaded [0:BOOT_DEPTH-1];
    logic [7:0] boot_off_shadow = 8'h00;

    hmd_req_if req_ch();
    hmd_rsp_if rsp_ch();

    handheld_memory_map_with_oam_dma_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    hmd_result_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("** handheld_memory_map_with_oam_dma_unit: FAILED **");
            $finish;
        end
    end

    // Offers one request and returns at the edge where it is accepted. The
    // valid line stays high straight into the next request when no gap is drawn.
    task automatic drive_item(input logic [2:0] op, input logic [15:0] addr,
                              input logic [7:0] d, input logic [7:0] cyc, input logic lk);
        int gap;
        gap = calm_sender ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= op;
        req_ch.address      <= addr;
        req_ch.data_in      <= d;
        req_ch.tick_cycles  <= cyc;
        req_ch.video_locked <= lk;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // Spare commands change nothing but still get a result; they do not count.
        if (op < CMD_SPARE_LO)
            sent_count++;
        if (op == CMD_LOAD_BOOT)
            boot_loaded[addr[7:0]] = 1'b1;
        if (op == CMD_LOAD_ROM && addr == AD_BOOT_OFF)
            boot_off_shadow = d;
        if (op == CMD_WRITE && addr == AD_BOOT_OFF && boot_off_shadow != BOOT_OFF_SET)
            boot_off_shadow = d;
    endtask

    // Like drive_item, but first loads any boot ROM entry the request could read.
    // A read of the low page with the overlay on needs its entry; a transfer from
    // page zero may read the first 160 boot ROM entries when its copy runs, so all
    // of the boot ROM is loaded before such a transfer starts.
    task automatic put_item(input logic [2:0] op, input logic [15:0] addr,
                            input logic [7:0] d, input logic [7:0] cyc, input logic lk);
        logic [7:0] hi;
        hi = $urandom_range(0, 255);
        if (op == CMD_READ && addr < BOOT_LIMIT && boot_off_shadow == 8'h00
            && !boot_loaded[addr[7:0]])
            drive_item(CMD_LOAD_BOOT, {hi, addr[7:0]}, $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 1));
        if (op == CMD_WRITE && addr == AD_DMA && d == 8'h00)
        begin
            for (int e = 0; e < BOOT_DEPTH; e++)
                if (!boot_loaded[e])
                    drive_item(CMD_LOAD_BOOT, {hi, e[7:0]}, $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 1));
        end
        drive_item(op, addr, d, cyc, lk);
    endtask

    // Addresses are drawn by region, with extra weight on the places where the
    // map has rules and on small windows that make reads hit earlier writes.
    function automatic logic [15:0] pick_addr();
        case ($urandom_range(0, 15))
            0:       return $urandom_range(0, 255);
            1:       return $urandom_range(ROM_LOW, ROM_TOP);
            2:       return $urandom_range(VRAM_BASE, VRAM_TOP);
            3:       return WRAM_BASE + $urandom_range(0, 63);
            4, 5:    return OAM_BASE + $urandom_range(0, 159);
            6:       return $urandom_range(UNUSED_BASE, UNUSED_TOP);
            7:       return AD_JOYPAD;
            8:       return AD_DIVIDER;
            9:       return AD_DMA;
            10:      return AD_BOOT_OFF;
            11:      return $urandom_range(IO_BASE, 16'hFFFF);
            12:      return HRAM_BASE + $urandom_range(0, 15);
            13:
                case ($urandom_range(0, 7))
                    0:       return ROM_TOP;
                    1:       return VRAM_BASE;
                    2:       return VRAM_TOP;
                    3:       return OAM_TOP;
                    4:       return UNUSED_BASE;
                    5:       return UNUSED_TOP;
                    6:       return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Result side: before each result ready may be dropped at random, except
    // during calm stretches, and once a long hold-off lets the block fill up
    // while the sender keeps offering requests.
    initial
    begin : receiver
        int gap;
        int taken;
        taken = 0;
        forever
        begin
            gap = calm_receiver ? 0 : $urandom_range(0, 9);
            if (taken == HOLD_OFF_AT)
                gap = HOLD_OFF_CYCLES;
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            taken++;
            if ($urandom_range(0, 31) == 0)
                calm_receiver = !calm_receiver;
        end
    end

    initial
    begin : stimulus
        int          directed_total;
        int          pick;
        int          n;
        logic [15:0] addr;
        logic [7:0]  page;
        logic [7:0]  lo;
        logic [7:0]  amount;
        logic        lk;

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.command      <= CMD_READ;
        req_ch.address      <= 16'h0000;
        req_ch.data_in      <= 8'h00;
        req_ch.tick_cycles  <= 8'h00;
        req_ch.video_locked <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The boot ROM load at 0xFF00 checks that only the low
        // byte of the address picks the entry.
        put_item(CMD_LOAD_BOOT, IO_BASE,     8'hA5, 8'h00, 1'b0);
        put_item(CMD_LOAD_BOOT, 16'h00FF,    8'h5A, 8'hFF, 1'b1);
        put_item(CMD_READ,      16'h0000,    8'h00, 8'h00, 1'b0);
        // A ROM load under the overlay must not show while the overlay is on.
        put_item(CMD_LOAD_ROM,  16'h0000,    8'h3C, 8'h00, 1'b0);
        put_item(CMD_READ,      16'h00FF,    8'hFF, 8'hFF, 1'b1);
        // Writes into ROM space are dropped.
        put_item(CMD_WRITE,     ROM_TOP,     8'hFF, 8'h00, 1'b0);
        put_item(CMD_READ,      ROM_TOP,     8'h00, 8'h00, 1'b0);
        // Video RAM takes writes only while unlocked and reads 0xFF when locked.
        put_item(CMD_WRITE,     VRAM_BASE,   8'h77, 8'h00, 1'b0);
        put_item(CMD_WRITE,     VRAM_TOP,    8'h11, 8'h00, 1'b1);
        put_item(CMD_READ,      VRAM_BASE,   8'h00, 8'h00, 1'b1);
        put_item(CMD_READ,      VRAM_BASE,   8'h00, 8'h00, 1'b0);
        // The unused area is blocked whatever the lock says.
        put_item(CMD_WRITE,     UNUSED_TOP,  8'h44, 8'h00, 1'b0);
        put_item(CMD_READ,      UNUSED_BASE, 8'h00, 8'h00, 1'b0);
        // Divider and joypad writes come out as flags and are not stored.
        put_item(CMD_WRITE,     AD_DIVIDER,  8'h9C, 8'h00, 1'b0);
        put_item(CMD_WRITE,     AD_JOYPAD,   8'h30, 8'h00, 1'b0);
        // Transfer from work RAM: the elapsed count wraps past 255 on the second
        // tick and the transfer stays pending, the third tick completes it.
        put_item(CMD_LOAD_ROM,  WRAM_BASE,   8'h81, 8'h00, 1'b0);
        put_item(CMD_WRITE,     AD_DMA,      WRAM_PAGE, 8'h00, 1'b0);
        put_item(CMD_TICK,      16'h0000,    8'h00, 8'd100, 1'b0);
        put_item(CMD_TICK,      16'hFFFF,    8'hFF, 8'd200, 1'b0);
        put_item(CMD_TICK,      16'h0000,    8'h00, 8'd120, 1'b0);
        put_item(CMD_READ,      OAM_BASE,    8'h00, 8'h00, 1'b0);
        // Setting the boot-off byte to one latches it: the write of zero after
        // it is dropped and the low page keeps showing the main store.
        put_item(CMD_WRITE,     AD_BOOT_OFF, BOOT_OFF_SET, 8'h00, 1'b0);
        put_item(CMD_WRITE,     AD_BOOT_OFF, 8'h00, 8'h00, 1'b0);
        put_item(CMD_READ,      16'h0000,    8'h00, 8'h00, 1'b0);
        // A spare command with every field at its top, and a tick with nothing
        // pending.
        put_item(CMD_SPARE_HI,  16'hFFFF,    8'hFF, 8'hFF, 1'b1);
        put_item(CMD_TICK,      16'hFFFF,    8'hFF, 8'hFF, 1'b0);
        directed_total = sent_count;

        // Random part, mostly short well-formed sequences with random content.
        while (sent_count < directed_total + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 31) == 0)
                calm_sender = !calm_sender;
            pick = $urandom_range(0, 99);
            lk = ($urandom_range(0, 2) == 0);
            if (pick < 25)
            begin
                // Lone access anywhere in the map.
                put_item($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, pick_addr(),
                         $urandom_range(0, 255), $urandom_range(0, 255), lk);
            end
            else if (pick < 42)
            begin
                // Write and read back, the read under its own lock state.
                addr = pick_addr();
                put_item(CMD_WRITE, addr, $urandom_range(0, 255), $urandom_range(0, 255), lk);
                put_item(CMD_READ, addr, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 2) == 0);
            end
            else if (pick < 60)
            begin
                // Object table transfer: seed the source page, start, tick until
                // done or not, with reads mixed in, then look at the table.
                case ($urandom_range(0, 6))
                    0:       page = 8'h00;
                    1:       page = VRAM_PAGE;
                    2:       page = OAM_PAGE;
                    3:       page = 8'hFF;
                    4:       page = $urandom_range(0, 255);
                    default: page = WRAM_PAGE;
                endcase
                repeat ($urandom_range(0, 3))
                begin
                    lo = $urandom_range(0, 255);
                    put_item(CMD_LOAD_ROM, {page, lo}, $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 1));
                end
                put_item(CMD_WRITE, AD_DMA, page, $urandom_range(0, 255), $urandom_range(0, 1));
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    if ($urandom_range(0, 2) == 0)
                        put_item(CMD_READ, pick_addr(), $urandom_range(0, 255),
                                 $urandom_range(0, 255), $urandom_range(0, 1));
                    amount = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(20, 90);
                    put_item(CMD_TICK, $urandom_range(0, 65535), $urandom_range(0, 255),
                             amount, $urandom_range(0, 3) == 0);
                end
                repeat ($urandom_range(1, 3))
                    put_item(CMD_READ, OAM_BASE + $urandom_range(0, 159),
                             $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
            end
            else if (pick < 70)
            begin
                // Direct load, then a read that may or may not see it.
                addr = pick_addr();
                put_item(CMD_LOAD_ROM, addr, $urandom_range(0, 255), $urandom_range(0, 255), lk);
                put_item(CMD_READ, addr, $urandom_range(0, 255), $urandom_range(0, 255), lk);
            end
            else if (pick < 78)
            begin
                // Boot ROM load and a read of the low page.
                addr = $urandom_range(0, 65535);
                put_item(CMD_LOAD_BOOT, addr, $urandom_range(0, 255),
                         $urandom_range(0, 255), lk);
                lo = $urandom_range(0, 1) ? addr[7:0] : $urandom_range(0, 255);
                put_item(CMD_READ, {8'h00, lo}, $urandom_range(0, 255),
                         $urandom_range(0, 255), lk);
            end
            else if (pick < 86)
            begin
                // Boot-off byte: write it, or force it with a load, which is the
                // only way back once it holds one.
                case ($urandom_range(0, 3))
                    0:       lo = 8'h00;
                    1:       lo = BOOT_OFF_SET;
                    default: lo = $urandom_range(0, 255);
                endcase
                put_item($urandom_range(0, 2) == 0 ? CMD_LOAD_ROM : CMD_WRITE, AD_BOOT_OFF,
                         lo, $urandom_range(0, 255), lk);
                put_item(CMD_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), lk);
            end
            else if (pick < 92)
            begin
                put_item(CMD_WRITE, $urandom_range(0, 1) ? AD_DIVIDER : AD_JOYPAD,
                         $urandom_range(0, 255), $urandom_range(0, 255), lk);
            end
            else if (pick < 97)
            begin
                put_item(CMD_TICK, $urandom_range(0, 65535), $urandom_range(0, 255),
                         $urandom_range(0, 255), lk);
            end
            else
            begin
                put_item($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI), $urandom_range(0, 65535),
                         $urandom_range(0, 255), $urandom_range(0, 255), lk);
            end
        end

        // Wait for the last results, then let the pipeline run dry.
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("** handheld_memory_map_with_oam_dma_unit: PASSED **");
        else
            $display("** handheld_memory_map_with_oam_dma_unit: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/hmd_pkg.sv
rtl/hmd_req_if.sv
rtl/hmd_rsp_if.sv
rtl/hmd_ram.sv
rtl/hmd_ctrl.sv
rtl/hmd_datapath.sv
rtl/handheld_memory_map_with_oam_dma_unit.sv
sim/hmd_result_checker.sv
sim/testbench.sv
